>>> rtl/sffr_pkg.sv
// ----------------------------------------------------------------------------
// sffr_pkg
// Shared types and constants for the sync/length frame receiver with a
// Fletcher-8 check.
// ----------------------------------------------------------------------------
package sffr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_DESC    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_CMD     = 8'd3;

    // Reset values of the registers
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h75;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h65;
    localparam logic [BYTE_W-1:0] EXP_DESC_RST    = 8'h00;
    localparam logic [BYTE_W-1:0] EXP_CMD_RST     = 8'h00;

    // Payload positions of the echo and error code in an ack reply
    localparam logic [BYTE_W-1:0] ECHO_POS    = 8'd2;
    localparam logic [BYTE_W-1:0] CODE_POS    = 8'd3;
    localparam logic [BYTE_W-1:0] ACK_MIN_LEN = 8'd4;

    // Output item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] exp_desc_set;
        logic [BYTE_W-1:0] exp_command;
    } sffr_cfg_t;

    typedef struct packed {
        logic              item_kind;
        logic [BYTE_W-1:0] frame_desc_set;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic              checksum_ok;
        logic              ack_ok;
        logic [BYTE_W-1:0] ack_error_code;
    } sffr_result_t;

endpackage

>>> rtl/sffr_cfg_regs.sv
// ----------------------------------------------------------------------------
// sffr_cfg_regs
// Configuration register file: sync bytes and the expected ack fields.
// ----------------------------------------------------------------------------
module sffr_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [sffr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sffr_pkg::BYTE_W-1:0]    cfg_data,
    output sffr_pkg::sffr_cfg_t            cfg
);
    import sffr_pkg::*;

    sffr_cfg_t cfg_reg;

    // Writes to indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first   <= SYNC_FIRST_RST;
            cfg_reg.sync_second  <= SYNC_SECOND_RST;
            cfg_reg.exp_desc_set <= EXP_DESC_RST;
            cfg_reg.exp_command  <= EXP_CMD_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_SYNC_FIRST)  cfg_reg.sync_first   <= cfg_data;
            if (cfg_index == REG_SYNC_SECOND) cfg_reg.sync_second  <= cfg_data;
            if (cfg_index == REG_EXP_DESC)    cfg_reg.exp_desc_set <= cfg_data;
            if (cfg_index == REG_EXP_CMD)     cfg_reg.exp_command  <= cfg_data;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/sffr_parser.sv
// ----------------------------------------------------------------------------
// sffr_parser
// Frame state machine with running Fletcher-8 sums. One byte per cycle;
// produces at most one result item per accepted byte.
// ----------------------------------------------------------------------------
module sffr_parser
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    input  logic [sffr_pkg::BYTE_W-1:0] rx_byte,
    input  sffr_pkg::sffr_cfg_t         cfg,
    output logic                        res_valid,
    output sffr_pkg::sffr_result_t      res
);
    import sffr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_DESC  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHK1  = 3'd5,
        PH_CHK2  = 3'd6
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] sum_lo_reg, sum_lo_next;
    logic [BYTE_W-1:0] sum_hi_reg, sum_hi_next;
    logic [BYTE_W-1:0] desc_reg, desc_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] echo_reg, echo_next;
    logic [BYTE_W-1:0] code_reg, code_next;
    logic [BYTE_W-1:0] chk1_reg, chk1_next;

    logic [BYTE_W-1:0] acc_lo;
    logic [BYTE_W-1:0] acc_hi;
    logic [BYTE_W-1:0] count_inc;
    logic              ck_ok;
    logic              long_frame;
    phase_t            hunt_phase;

    // Fletcher step on the current byte
    assign acc_lo    = sum_lo_reg + rx_byte;
    assign acc_hi    = sum_hi_reg + acc_lo;
    assign count_inc = count_reg + 8'd1;

    assign ck_ok      = (chk1_reg == sum_lo_reg) && (rx_byte == sum_hi_reg);
    assign long_frame = (len_reg >= ACK_MIN_LEN);
    assign hunt_phase = (rx_byte == cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;

    // Next-state and result logic
    always_comb
    begin
        phase_next  = phase_reg;
        sum_lo_next = sum_lo_reg;
        sum_hi_next = sum_hi_reg;
        desc_next   = desc_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        echo_next   = echo_reg;
        code_next   = code_reg;
        chk1_next   = chk1_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.frame_desc_set = desc_reg;

        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HUNT2:
                begin
                    if (rx_byte == cfg.sync_second)
                    begin
                        // Sums restart over both sync bytes
                        sum_lo_next = cfg.sync_first + rx_byte;
                        sum_hi_next = cfg.sync_first + cfg.sync_first + rx_byte;
                        phase_next  = PH_DESC;
                    end
                    else
                    begin
                        phase_next = hunt_phase;
                    end
                end
                PH_DESC:
                begin
                    desc_next   = rx_byte;
                    sum_lo_next = acc_lo;
                    sum_hi_next = acc_hi;
                    phase_next  = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next    = rx_byte;
                    count_next  = '0;
                    echo_next   = '0;
                    code_next   = '0;
                    sum_lo_next = acc_lo;
                    sum_hi_next = acc_hi;
                    phase_next  = (rx_byte == '0) ? PH_CHK1 : PH_DATA;
                end
                PH_DATA:
                begin
                    sum_lo_next = acc_lo;
                    sum_hi_next = acc_hi;
                    if (count_reg == ECHO_POS) echo_next = rx_byte;
                    if (count_reg == CODE_POS) code_next = rx_byte;
                    res_valid         = 1'b1;
                    res.item_kind     = KIND_PAYLOAD;
                    res.payload_byte  = rx_byte;
                    res.payload_index = count_reg;
                    count_next        = count_inc;
                    if (count_inc == len_reg) phase_next = PH_CHK1;
                end
                PH_CHK1:
                begin
                    chk1_next  = rx_byte;
                    phase_next = PH_CHK2;
                end
                PH_CHK2:
                begin
                    res_valid          = 1'b1;
                    res.item_kind      = KIND_STATUS;
                    res.payload_index  = len_reg;
                    res.checksum_ok    = ck_ok;
                    res.ack_ok         = ck_ok && long_frame
                                         && (desc_reg == cfg.exp_desc_set)
                                         && (echo_reg == cfg.exp_command)
                                         && (code_reg == '0);
                    res.ack_error_code = long_frame ? code_reg : '0;
                    phase_next         = PH_HUNT1;
                end
                default:
                begin
                    phase_next = hunt_phase;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT1;
            sum_lo_reg <= '0;
            sum_hi_reg <= '0;
            desc_reg   <= '0;
            len_reg    <= '0;
            count_reg  <= '0;
            echo_reg   <= '0;
            code_reg   <= '0;
            chk1_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            sum_lo_reg <= sum_lo_next;
            sum_hi_reg <= sum_hi_next;
            desc_reg   <= desc_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            echo_reg   <= echo_next;
            code_reg   <= code_next;
            chk1_reg   <= chk1_next;
        end
    end

endmodule

>>> rtl/sffr_out_buf.sv
// ----------------------------------------------------------------------------
// sffr_out_buf
// Two-entry result buffer. Decouples the output stall from the input side;
// the upstream stall is a registered full flag.
// ----------------------------------------------------------------------------
module sffr_out_buf
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sffr_pkg::sffr_result_t push_data,
    input  logic                   pop,
    output logic                   full,
    output logic                   not_empty,
    output sffr_pkg::sffr_result_t head
);
    import sffr_pkg::*;

    sffr_result_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/sync_fletcher_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_fletcher_frame_receiver
// Hunts for a two-byte sync pattern, parses descriptor set, length and
// payload, checks the Fletcher-8 trailer and reports ack status.
//
//   channel | signals                          | direction
//   --------+----------------------------------+-----------
//   input   | in_valid, in_stall, rx_byte      | in (stall out)
//   output  | out_valid, out_stall, item_kind..| out (stall in)
//   config  | cfg_valid, cfg_ready, cfg_index, | in (ready out)
//           | cfg_data                         |
//
// One byte is taken per cycle while in_stall is low; its item appears in the
// output buffer on the next cycle. The parser state and sums update in the
// accept cycle. in_stall is the registered full flag of a two-entry output
// buffer, so output stalls reach the input through a register and no item is
// lost. Reset puts the parser in sync hunt and loads the default sync bytes.
// ----------------------------------------------------------------------------
module sync_fletcher_frame_receiver
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sffr_pkg::BYTE_W-1:0]    rx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           item_kind,
    output logic [sffr_pkg::BYTE_W-1:0]    frame_desc_set,
    output logic [sffr_pkg::BYTE_W-1:0]    payload_byte,
    output logic [sffr_pkg::BYTE_W-1:0]    payload_index,
    output logic                           checksum_ok,
    output logic                           ack_ok,
    output logic [sffr_pkg::BYTE_W-1:0]    ack_error_code,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sffr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sffr_pkg::BYTE_W-1:0]    cfg_data
);
    import sffr_pkg::*;

    sffr_cfg_t    cfg;
    sffr_result_t res;
    sffr_result_t head;
    logic         res_valid;
    logic         buf_full;
    logic         in_take;
    logic         out_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign in_take   = in_valid && !buf_full;
    assign out_take  = out_valid && !out_stall;

    sffr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sffr_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_take),
        .rx_byte    (rx_byte),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .res        (res)
    );

    sffr_out_buf u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (out_take),
        .full      (buf_full),
        .not_empty (out_valid),
        .head      (head)
    );

    // Result fields
    assign item_kind      = head.item_kind;
    assign frame_desc_set = head.frame_desc_set;
    assign payload_byte   = head.payload_byte;
    assign payload_index  = head.payload_index;
    assign checksum_ok    = head.checksum_ok;
    assign ack_ok         = head.ack_ok;
    assign ack_error_code = head.ack_error_code;

endmodule
